// ===== src/htd_pkg.sv =====
// Shared types and constants of the Huffman tree decoder.
package htd_pkg;

  localparam int unsigned NodeDepthDef = 512;
  localparam int unsigned MaxCodeBits  = 32;
  localparam int unsigned DataBits     = 8;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DATA  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_CONFLICT = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    op_e         opcode;
    logic [7:0]  entry_symbol;
    logic [5:0]  code_length;
    logic [31:0] code_bits;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       symbol_valid;
    status_e    status;
    logic       last_of_item;
    logic       all_done;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

// ===== src/htd_if.sv =====
// Handshake channel interfaces of the Huffman tree decoder.
interface htd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  entry_symbol;
  logic [5:0]  code_length;
  logic [31:0] code_bits;
  logic [7:0]  data_byte;

  modport source (output valid, opcode, entry_symbol, code_length, code_bits, data_byte,
                  input ready);
  modport sink (input valid, opcode, entry_symbol, code_length, code_bits, data_byte,
                output ready);
endinterface

interface htd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       symbol_valid;
  logic [1:0] status;
  logic       last_of_item;
  logic       all_done;

  modport source (output valid, out_symbol, symbol_valid, status, last_of_item, all_done,
                  input ready);
  modport sink (input valid, out_symbol, symbol_valid, status, last_of_item, all_done,
                output ready);
endinterface

interface htd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] symbol_total;

  modport source (output valid, symbol_total, input ready);
  modport sink (input valid, symbol_total, output ready);
endinterface

// ===== src/htd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module htd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/htd_walker.sv =====
// Tree walk sequencer: code insertion, bit-serial decoding and result ordering.
module htd_walker #(
  parameter int unsigned NODE_DEPTH = htd_pkg::NodeDepthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  input  htd_pkg::item_t                      item_i,
  output logic                                item_ready_o,
  input  logic [31:0]                         symbol_total_i,
  output htd_pkg::push_t                      push_o,
  input  logic                                push_ready_i,
  output logic                                mem_we_o,
  output logic [$clog2(NODE_DEPTH)-1:0]       mem_waddr_o,
  output logic [2*$clog2(NODE_DEPTH)+10:0]    mem_wdata_o,
  output logic                                mem_re_o,
  output logic [$clog2(NODE_DEPTH)-1:0]       mem_raddr_o,
  input  logic [2*$clog2(NODE_DEPTH)+10:0]    mem_rdata_i
);
  import htd_pkg::*;

  localparam int unsigned IDXW = $clog2(NODE_DEPTH);
  localparam int unsigned CNTW = IDXW + 1;
  localparam int unsigned SW   = ((CNTW > 6) ? CNTW : 6) + 1;

  typedef struct packed {
    logic [IDXW-1:0] zl;
    logic [IDXW-1:0] ol;
    logic [1:0]      pr;
    logic            leaf;
    logic [7:0]      sym;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_L_WALK,
    S_L_LINK,
    S_L_NEW,
    S_D_WALK,
    S_D_FLUSH,
    S_RESULT
  } state_e;

  state_e          state_q, state_d;
  item_t           item_q, item_d;
  logic            cur_root_q, cur_root_d;
  logic [IDXW-1:0] cur_idx_q, cur_idx_d;
  logic [5:0]      cnt_q, cnt_d;
  node_t           par_q, par_d;
  logic [IDXW-1:0] new_idx_q, new_idx_d;
  logic [CNTW-1:0] used_q, used_d;
  logic [IDXW-1:0] walk_q, walk_d;
  logic [31:0]     prod_q, prod_d;
  logic [IDXW-1:0] root_zl_q, root_zl_d;
  logic [IDXW-1:0] root_ol_q, root_ol_d;
  logic [1:0]      root_pr_q, root_pr_d;
  logic            pend_valid_q, pend_valid_d;
  logic [7:0]      pend_sym_q, pend_sym_d;
  logic            pend_done_q, pend_done_d;
  status_e         stat_q, stat_d;

  node_t           cur;
  node_t           wnode;
  logic [5:0]      cnt_m1;
  logic            bit_sel;
  logic            has_link;
  logic [IDXW-1:0] child;
  logic [IDXW-1:0] used_idx;
  logic            done_now;
  logic [SW-1:0]   need_sum;

  assign cur = cur_root_q ? node_t'{zl: root_zl_q, ol: root_ol_q, pr: root_pr_q,
                                    leaf: 1'b0, sym: 8'd0}
                          : node_t'(mem_rdata_i);
  assign cnt_m1   = cnt_q - 6'd1;
  assign bit_sel  = (state_q == S_D_WALK) ? item_q.data_byte[cnt_m1[2:0]]
                                          : item_q.code_bits[cnt_m1[4:0]];
  assign has_link = bit_sel ? cur.pr[1] : cur.pr[0];
  assign child    = bit_sel ? cur.ol : cur.zl;
  assign used_idx = used_q[IDXW-1:0];
  assign done_now = (prod_q >= symbol_total_i);
  assign need_sum = SW'(used_q) + SW'(cnt_q);
  assign mem_wdata_o = wnode;

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cur_root_d   = cur_root_q;
    cur_idx_d    = cur_idx_q;
    cnt_d        = cnt_q;
    par_d        = par_q;
    new_idx_d    = new_idx_q;
    used_d       = used_q;
    walk_d       = walk_q;
    prod_d       = prod_q;
    root_zl_d    = root_zl_q;
    root_ol_d    = root_ol_q;
    root_pr_d    = root_pr_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_done_d  = pend_done_q;
    stat_d       = stat_q;
    item_ready_o = 1'b0;
    push_o       = '0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = cur_idx_q;
    wnode        = par_q;
    mem_re_o     = 1'b0;
    mem_raddr_o  = child;

    case (state_q)
      S_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          item_d = item_i;
          case (item_i.opcode)
            OP_LOAD: begin
              if ((item_i.code_length == 6'd0) ||
                  (item_i.code_length > 6'(MaxCodeBits))) begin
                stat_d  = ST_CONFLICT;
                state_d = S_RESULT;
              end else begin
                cur_root_d = 1'b1;
                cnt_d      = item_i.code_length;
                state_d    = S_L_WALK;
              end
            end
            OP_DATA: begin
              mem_re_o    = 1'b1;
              mem_raddr_o = walk_q;
              cur_idx_d   = walk_q;
              cur_root_d  = (walk_q == '0);
              cnt_d       = 6'(DataBits);
              state_d     = S_D_WALK;
            end
            OP_CLEAR: begin
              root_pr_d = 2'b00;
              used_d    = CNTW'(1);
              walk_d    = '0;
              prod_d    = '0;
              stat_d    = ST_OK;
              state_d   = S_RESULT;
            end
            default: begin
            end
          endcase
        end
      end

      S_L_WALK: begin
        if (!cur_root_q && cur.leaf) begin
          stat_d  = ST_CONFLICT;
          state_d = S_RESULT;
        end else if (cnt_q == 6'd0) begin
          // path already exists: only an empty non-root node may become the leaf
          if (cur_root_q || (cur.pr != 2'b00)) begin
            stat_d  = ST_CONFLICT;
            state_d = S_RESULT;
          end else begin
            new_idx_d = cur_idx_q;
            state_d   = S_L_NEW;
          end
        end else if (has_link) begin
          mem_re_o   = 1'b1;
          cur_idx_d  = child;
          cur_root_d = 1'b0;
          cnt_d      = cnt_m1;
        end else if (need_sum > SW'(NODE_DEPTH)) begin
          stat_d  = ST_FULL;
          state_d = S_RESULT;
        end else begin
          par_d   = cur;
          state_d = S_L_LINK;
        end
      end

      S_L_LINK: begin
        // hook the first new node under the deepest existing node
        if (cur_root_q) begin
          if (bit_sel) begin
            root_ol_d = used_idx;
          end else begin
            root_zl_d = used_idx;
          end
          root_pr_d = root_pr_q | (bit_sel ? 2'b10 : 2'b01);
        end else begin
          mem_we_o = 1'b1;
          wnode    = par_q;
          if (bit_sel) begin
            wnode.ol = used_idx;
          end else begin
            wnode.zl = used_idx;
          end
          wnode.pr = par_q.pr | (bit_sel ? 2'b10 : 2'b01);
        end
        new_idx_d = used_idx;
        used_d    = used_q + CNTW'(1);
        cnt_d     = cnt_m1;
        state_d   = S_L_NEW;
      end

      S_L_NEW: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = new_idx_q;
        if (cnt_q != 6'd0) begin
          wnode    = '0;
          if (bit_sel) begin
            wnode.ol = used_idx;
          end else begin
            wnode.zl = used_idx;
          end
          wnode.pr  = bit_sel ? 2'b10 : 2'b01;
          new_idx_d = used_idx;
          used_d    = used_q + CNTW'(1);
          cnt_d     = cnt_m1;
        end else begin
          wnode      = '0;
          wnode.leaf = 1'b1;
          wnode.sym  = item_q.entry_symbol;
          stat_d     = ST_OK;
          state_d    = S_RESULT;
        end
      end

      S_D_WALK: begin
        if (!cur_root_q && cur.leaf) begin
          // leaf reached: retire the previous symbol, park this one
          if (!pend_valid_q || push_ready_i) begin
            push_o.valid            = pend_valid_q;
            push_o.res.out_symbol   = pend_sym_q;
            push_o.res.symbol_valid = 1'b1;
            push_o.res.status       = ST_OK;
            push_o.res.last_of_item = 1'b0;
            push_o.res.all_done     = pend_done_q;
            pend_valid_d = 1'b1;
            pend_sym_d   = cur.sym;
            pend_done_d  = ((prod_q + 32'd1) >= symbol_total_i);
            prod_d       = prod_q + 32'd1;
            cur_root_d   = 1'b1;
          end
        end else if ((cnt_q == 6'd0) || done_now) begin
          walk_d  = cur_root_q ? '0 : cur_idx_q;
          state_d = S_D_FLUSH;
        end else if (has_link) begin
          mem_re_o   = 1'b1;
          cur_idx_d  = child;
          cur_root_d = 1'b0;
          cnt_d      = cnt_m1;
        end else begin
          walk_d  = '0;
          stat_d  = ST_MISSING;
          state_d = S_RESULT;
        end
      end

      S_D_FLUSH: begin
        push_o.valid = 1'b1;
        push_o.res.last_of_item = 1'b1;
        push_o.res.status       = ST_OK;
        if (pend_valid_q) begin
          push_o.res.out_symbol   = pend_sym_q;
          push_o.res.symbol_valid = 1'b1;
          push_o.res.all_done     = pend_done_q;
        end else begin
          push_o.res.all_done = done_now;
        end
        if (push_ready_i) begin
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      S_RESULT: begin
        push_o.valid = 1'b1;
        if (pend_valid_q) begin
          push_o.res.out_symbol   = pend_sym_q;
          push_o.res.symbol_valid = 1'b1;
          push_o.res.status       = ST_OK;
          push_o.res.all_done     = pend_done_q;
          if (push_ready_i) begin
            pend_valid_d = 1'b0;
          end
        end else begin
          push_o.res.status       = stat_q;
          push_o.res.last_of_item = 1'b1;
          push_o.res.all_done     = done_now;
          if (push_ready_i) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_root_q   <= 1'b1;
      used_q       <= CNTW'(1);
      walk_q       <= '0;
      prod_q       <= '0;
      root_pr_q    <= 2'b00;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_root_q   <= cur_root_d;
      used_q       <= used_d;
      walk_q       <= walk_d;
      prod_q       <= prod_d;
      root_pr_q    <= root_pr_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    cur_idx_q   <= cur_idx_d;
    cnt_q       <= cnt_d;
    par_q       <= par_d;
    new_idx_q   <= new_idx_d;
    root_zl_q   <= root_zl_d;
    root_ol_q   <= root_ol_d;
    pend_sym_q  <= pend_sym_d;
    pend_done_q <= pend_done_d;
    stat_q      <= stat_d;
  end

endmodule

// ===== src/huffman_tree_decoder_core.sv =====
// Steps to an item's last result: clear goes straight to its result; load walks the existing
// path, links the parent and makes one write per new node; data byte makes up to eight bit
// reads, one end check, one push per decoded symbol and one flush; output stalls hold pushes.
// Throughput: one item at a time, taken the cycle after its predecessor's last push; the bit
// walk through the node store read port sets the rate.
// Reset: tree empty (root only), counters and symbol_total zero; no clearing pass is needed.
module huffman_tree_decoder_core #(
  parameter int unsigned NODE_DEPTH = htd_pkg::NodeDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  htd_cfg_if.sink   cfg_i,
  htd_in_if.sink    in_i,
  htd_out_if.source out_o
);
  import htd_pkg::*;

  localparam int unsigned IDXW = $clog2(NODE_DEPTH);
  localparam int unsigned NW   = 2 * IDXW + 11;

  logic [31:0]     symbol_total_q;
  item_t           item;
  push_t           push;
  logic            push_ready;
  logic            out_valid_q;
  res_t            out_res_q;
  logic            mem_we;
  logic [IDXW-1:0] mem_waddr;
  logic [NW-1:0]   mem_wdata;
  logic            mem_re;
  logic [IDXW-1:0] mem_raddr;
  logic [NW-1:0]   mem_rdata;

  // Configuration: always take the request; the user must write it only while idle, as the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_total_q <= '0;
    end else if (cfg_i.valid) begin
      symbol_total_q <= cfg_i.symbol_total;
    end
  end

  assign item.opcode       = op_e'(in_i.opcode);
  assign item.entry_symbol = in_i.entry_symbol;
  assign item.code_length  = in_i.code_length;
  assign item.code_bits    = in_i.code_bits;
  assign item.data_byte    = in_i.data_byte;

  htd_walker #(
    .NODE_DEPTH(NODE_DEPTH)
  ) u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (in_i.valid),
    .item_i        (item),
    .item_ready_o  (in_i.ready),
    .symbol_total_i(symbol_total_q),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // Node store: child links, link flags, leaf flag and symbol, one entry per node.
  htd_ram #(
    .WIDTH(NW),
    .DEPTH(NODE_DEPTH)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Output register: accept a new request whenever the slot is empty or draining.
  assign push_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push.valid && push_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push.valid && push_ready) begin
      out_res_q <= push.res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_symbol   = out_res_q.out_symbol;
  assign out_o.symbol_valid = out_res_q.symbol_valid;
  assign out_o.status       = out_res_q.status;
  assign out_o.last_of_item = out_res_q.last_of_item;
  assign out_o.all_done     = out_res_q.all_done;

endmodule
